[rtl/mbrc_pkg.sv]
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU reply checker.
// No dependencies; every other file of the block but mbrc_channels imports this package.
`timescale 1ns / 1ps

package mbrc_pkg;

  localparam int unsigned REG_COUNT_DEF = 7;   // registers in one reply
  localparam int unsigned OUT_REGS      = 7;   // registers shown on the result word
  localparam int unsigned CFG_W         = 16;  // widest configuration register
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd2;
  localparam logic [7:0]  FUNC_CODE_RST  = 8'd3;
  localparam logic [15:0] TIMEOUT_RST    = 16'd500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CRC     = 3'd1,
    ST_HEADER  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_SHORT   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } mbrc_item_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] timeout_ticks;
  } mbrc_cfg_t;

  typedef struct packed {
    status_e                    status;
    logic [4:0]                 byte_count;
    logic                       values_valid;
    logic [OUT_REGS-1:0][15:0]  regs;
  } mbrc_result_t;

  // Fold one byte into a reflected CRC-16, eight shift/xor steps.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/mbrc_channels.sv]
// Valid/ready channel interfaces for the reply checker: request words in, result words out.
// Depends on nothing; payload fields are plain vectors.
`timescale 1ns / 1ps

interface mbrc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mbrc_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [4:0]         byte_count;
  logic               values_valid;
  logic signed [15:0] humidity_raw;
  logic signed [15:0] temperature_raw;
  logic [15:0]        conductivity;
  logic [15:0]        ph_raw;
  logic [15:0]        nitrogen;
  logic [15:0]        phosphorus;
  logic [15:0]        potassium;

  modport source (output valid, output status, output byte_count, output values_valid,
                  output humidity_raw, output temperature_raw, output conductivity,
                  output ph_raw, output nitrogen, output phosphorus, output potassium,
                  input ready);
  modport sink   (input valid, input status, input byte_count, input values_valid,
                  input humidity_raw, input temperature_raw, input conductivity,
                  input ph_raw, input nitrogen, input phosphorus, input potassium,
                  output ready);
endinterface

[rtl/mbrc_in_stage.sv]
// Input register of the reply checker: captures one request word per cycle while it is empty or its held word moves on.
// Depends on mbrc_pkg.
`timescale 1ns / 1ps

module mbrc_in_stage import mbrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  mbrc_item_t item_i,
  input  logic       adv_i,
  output logic       ready_o,
  output logic       valid_o,
  output mbrc_item_t item_o
);

  logic       valid_q;
  mbrc_item_t item_q;

  // empty, or the held word moves on this cycle
  assign ready_o = !valid_q || adv_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

[rtl/mbrc_frame_core.sv]
// Frame state of the reply checker: CRC fold, header check, register capture, verdict.
// Depends on mbrc_pkg; one word is handled per cycle when fire_i is high.
`timescale 1ns / 1ps

module mbrc_frame_core import mbrc_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  mbrc_item_t   item_i,
  input  mbrc_cfg_t    cfg_i,
  output logic         emit_o,
  output mbrc_result_t result_o
);

  localparam int unsigned FRAME_LEN = 5 + 2 * REG_COUNT;
  localparam int unsigned SEEN_W    = $clog2(FRAME_LEN + 1);
  localparam int unsigned KEEP      = (REG_COUNT < OUT_REGS) ? REG_COUNT : OUT_REGS;
  localparam logic [SEEN_W-1:0] LAST_DATA = SEEN_W'(FRAME_LEN - 2);
  localparam logic [7:0]        BYTE_CNT  = 8'((2 * REG_COUNT) % 256);

  logic              active_q, active_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [15:0]       crc_q, crc_d;
  logic              hdr_q, hdr_d;
  logic [15:0]       sil_q, sil_d;
  logic [15:0]       sil_inc;
  logic [7:0]        crc_lo_q, crc_lo_d;
  logic [15:0]       pend_q [KEEP];
  logic [15:0]       pend_d [KEEP];
  logic [15:0]       good_q [KEEP];
  logic [15:0]       good_d [KEEP];
  logic              good_seen_q, good_seen_d;
  logic [SEEN_W-1:0] off;
  logic [SEEN_W-1:0] reg_num;
  status_e           status;
  logic [7:0]        b;
  logic [OUT_REGS-1:0][15:0] reg_view;

  assign b       = item_i.rx_byte;
  assign off     = seen_q - SEEN_W'(3);
  assign reg_num = off >> 1;
  assign sil_inc = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;

  always_comb begin
    active_d    = active_q;
    seen_d      = seen_q;
    crc_d       = crc_q;
    hdr_d       = hdr_q;
    sil_d       = sil_q;
    crc_lo_d    = crc_lo_q;
    pend_d      = pend_q;
    good_d      = good_q;
    good_seen_d = good_seen_q;
    emit_o      = 1'b0;
    status      = ST_OK;
    if (fire_i) begin
      unique case (item_i.op)
        OP_START: begin
          active_d = 1'b1;
          seen_d   = '0;
          crc_d    = CRC_INIT;
          hdr_d    = 1'b1;
          sil_d    = '0;
          crc_lo_d = '0;
        end
        OP_BYTE: begin
          if (active_q) begin
            sil_d  = '0;
            seen_d = seen_q + SEEN_W'(1);
            if (seen_q < LAST_DATA) begin
              crc_d = crc_fold(crc_q, b);
              if (seen_q == SEEN_W'(0) && b != cfg_i.slave_address) hdr_d = 1'b0;
              if (seen_q == SEEN_W'(1) && b != cfg_i.function_code) hdr_d = 1'b0;
              if (seen_q == SEEN_W'(2) && b != BYTE_CNT)            hdr_d = 1'b0;
              if (seen_q >= SEEN_W'(3)) begin
                for (int k = 0; k < KEEP; k++) begin
                  if (reg_num == SEEN_W'(k)) begin
                    if (!off[0]) begin
                      pend_d[k][15:8] = b;
                    end else begin
                      pend_d[k][7:0] = b;
                    end
                  end
                end
              end
            end else if (seen_q == LAST_DATA) begin
              crc_lo_d = b;
            end else begin
              // last byte: judge the frame
              active_d = 1'b0;
              emit_o   = 1'b1;
              if (!hdr_q) begin
                status = ST_HEADER;
              end else if ({b, crc_lo_q} != crc_q) begin
                status = ST_CRC;
              end else begin
                status      = ST_OK;
                good_d      = pend_q;
                good_seen_d = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (active_q) begin
            sil_d = sil_inc;
            if (sil_inc >= cfg_i.timeout_ticks) begin
              active_d = 1'b0;
              emit_o   = 1'b1;
              status   = (seen_q == '0) ? ST_TIMEOUT : ST_SHORT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // registers beyond the frame read as zero
  for (genvar g = 0; g < OUT_REGS; g++) begin : g_view
    if (g < KEEP) begin : g_kept
      assign reg_view[g] = good_d[g];
    end else begin : g_zero
      assign reg_view[g] = '0;
    end
  end

  always_comb begin
    result_o.status       = status;
    result_o.byte_count   = 5'(seen_d);
    result_o.values_valid = good_seen_d;
    result_o.regs         = reg_view;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      seen_q      <= '0;
      crc_q       <= CRC_INIT;
      hdr_q       <= 1'b0;
      sil_q       <= '0;
      crc_lo_q    <= '0;
      good_seen_q <= 1'b0;
      for (int k = 0; k < KEEP; k++) good_q[k] <= '0;
    end else begin
      active_q    <= active_d;
      seen_q      <= seen_d;
      crc_q       <= crc_d;
      hdr_q       <= hdr_d;
      sil_q       <= sil_d;
      crc_lo_q    <= crc_lo_d;
      good_seen_q <= good_seen_d;
      good_q      <= good_d;
    end
  end

  // capture buffer is fully rewritten by any frame that passes
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

[rtl/mbrc_out_stage.sv]
// Result register of the reply checker: holds one result word until it is taken.
// Depends on mbrc_pkg.
`timescale 1ns / 1ps

module mbrc_out_stage import mbrc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic         emit_i,
  input  mbrc_result_t result_i,
  input  logic         ready_i,
  output logic         valid_o,
  output mbrc_result_t result_o,
  output logic         adv_o
);

  logic         valid_q;
  mbrc_result_t result_q;

  // empty, or the held word leaves this cycle
  assign adv_o    = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= fire_i && emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit_i) begin
      result_q <= result_i;
    end
  end

endmodule

[rtl/modbus_rtu_response_checker_unit.sv]
// Top level of the Modbus RTU read-registers reply checker.
// Depends on mbrc_pkg, mbrc_channels, mbrc_in_stage, mbrc_frame_core, mbrc_out_stage.
`timescale 1ns / 1ps

// The checker takes one request word per cycle while the result register has room:
// start a frame, one received byte, or one millisecond tick. A result word passes two
// registers, the input register and then the result register fed by the frame logic;
// the CRC byte fold between the two registers is combinational. A started frame expects
// 5 + 2*REG_COUNT bytes (address, function code, byte count, register data big-endian,
// CRC low, CRC high). The last byte yields one result: bad header ahead of CRC mismatch,
// else ok, which latches the register values. Ticks count silence since the last byte;
// reaching timeout_ticks ends the frame with a timeout (no bytes yet) or short-frame
// result. Bytes and ticks outside a frame produce nothing; a start during a frame drops
// it silently. Write configuration only while idle.

module modbus_rtu_response_checker_unit import mbrc_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  mbrc_req_if.sink             req_i,
  mbrc_rsp_if.source           rsp_o
);

  mbrc_cfg_t    cfg_q;
  mbrc_item_t   in_item;
  mbrc_item_t   s1_item;
  logic         s1_valid;
  logic         adv;
  logic         fire;
  logic         emit;
  mbrc_result_t core_res;
  mbrc_result_t out_res;

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address <= SLAVE_ADDR_RST;
      cfg_q.function_code <= FUNC_CODE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLAVE_ADDR: cfg_q.slave_address <= cfg_wdata_i[7:0];
        CFG_FUNC_CODE:  cfg_q.function_code <= cfg_wdata_i[7:0];
        CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_item.op      = req_i.operation;
  assign in_item.rx_byte = req_i.rx_byte;

  // Hold the accepted word until the frame logic can take it.
  mbrc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .item_i  (in_item),
    .adv_i   (adv),
    .ready_o (req_i.ready),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  // Advance the frame state whenever the result register has room.
  assign fire = s1_valid && adv;

  mbrc_frame_core #(.REG_COUNT(REG_COUNT)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (core_res)
  );

  mbrc_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .emit_i   (emit),
    .result_i (core_res),
    .ready_i  (rsp_o.ready),
    .valid_o  (rsp_o.valid),
    .result_o (out_res),
    .adv_o    (adv)
  );

  // Unpack the result word onto the channel fields.
  assign rsp_o.status          = out_res.status;
  assign rsp_o.byte_count      = out_res.byte_count;
  assign rsp_o.values_valid    = out_res.values_valid;
  assign rsp_o.humidity_raw    = signed'(out_res.regs[0]);
  assign rsp_o.temperature_raw = signed'(out_res.regs[1]);
  assign rsp_o.conductivity    = out_res.regs[2];
  assign rsp_o.ph_raw          = out_res.regs[3];
  assign rsp_o.nitrogen        = out_res.regs[4];
  assign rsp_o.phosphorus      = out_res.regs[5];
  assign rsp_o.potassium       = out_res.regs[6];

endmodule

[rtl/mbrc_checker.sv]
// Port-level assertions for the reply checker, attached to the top level by bind.
// Depends on mbrc_pkg and modbus_rtu_response_checker_unit.
`timescale 1ns / 1ps

module mbrc_checker import mbrc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] status_i,
  input logic [4:0] byte_count_i,
  input logic       values_valid_i
);

  logic vv_seen_q;

  // remember that a passing frame has been reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_seen_q <= 1'b0;
    end else if (rsp_valid_i && values_valid_i) begin
      vv_seen_q <= 1'b1;
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(byte_count_i))
    else $error("result word changed while stalled");

  a_vv_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && vv_seen_q |-> values_valid_i)
    else $error("values_valid dropped after a good frame");

  a_ok_sets_vv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_OK |-> values_valid_i)
    else $error("ok result without values_valid");

  a_timeout_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_TIMEOUT |-> byte_count_i == 5'd0)
    else $error("timeout result with bytes received");

endmodule

bind modbus_rtu_response_checker_unit mbrc_checker u_mbrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .byte_count_i   (rsp_o.byte_count),
  .values_valid_i (rsp_o.values_valid)
);

[dv/modbus_rtu_response_checker_unit_tb.sv]
// Self-checking testbench for the Modbus RTU reply checker: a directed table, random frames, then a zero-timeout case.
// Depends on mbrc_pkg, the mbrc_req_if / mbrc_rsp_if channels and modbus_rtu_response_checker_unit.
`timescale 1ns / 1ps

module modbus_rtu_response_checker_unit_tb;
  import mbrc_pkg::*;

  localparam int unsigned FRAME_BYTES  = 5 + 2 * REG_COUNT_DEF;  // full reply length
  localparam int unsigned CRC_SPAN     = FRAME_BYTES - 2;        // bytes covered by the CRC
  localparam logic [1:0]  OP_RSVD      = 2'd3;                   // unused operation code
  localparam int unsigned DRAIN_PAD    = 8;                      // lets words still in the two stages clear
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_WORDS  = 135;
  localparam int unsigned PHASE_REPLY  = 10;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned LIMIT_NS     = 2_000_000;

  typedef enum logic [1:0] {CS_LIT, CS_LO, CS_HI} crc_sel_e;
  typedef enum int {K_GOOD, K_BAD_CRC, K_BAD_HDR, K_SHORT, K_NOISE} frame_kind_e;

  // One directed word; pinned rows carry the status and count typed in by hand.
  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    crc_sel_e   sel;
    bit         pin;
    status_e    st;
    logic [4:0] cnt;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  mbrc_req_if req_if ();
  mbrc_rsp_if rsp_if ();

  modbus_rtu_response_checker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Pin tag travels beside the request word, so the monitor sees it at acceptance.
  bit         pin_en;
  status_e    pin_st;
  logic [4:0] pin_cnt;

  // Mirror of the checker: configuration copy and frame state.
  logic [7:0]  m_addr;
  logic [7:0]  m_func;
  logic [15:0] m_tmo;
  bit          frame_on;
  int unsigned nbytes;
  logic [15:0] crc_acc;
  bit          hdr_good;
  logic [15:0] quiet;
  logic [7:0]  crc_lo;
  logic [15:0] staged  [REG_COUNT_DEF];
  logic [15:0] latched [REG_COUNT_DEF];
  bit          latched_any;

  mbrc_result_t reply_q [$];   // replies predicted and not yet seen

  int          errors      = 0;
  int unsigned sent        = 0;
  int unsigned replies_seen = 0;
  int          send_pct;
  int          stall_pct;
  int          hold_req;
  int          hold_left;
  row_t        dir_tab [30];

  string reg_name [OUT_REGS] = '{"humidity_raw", "temperature_raw", "conductivity", "ph_raw",
                                 "nitrogen", "phosphorus", "potassium"};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Reflected CRC-16, shifted one bit at a time, LSB of the byte first.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic mbrc_result_t fill_reply(status_e st);
    mbrc_result_t r;
    r.status       = st;
    r.byte_count   = 5'(nbytes);
    r.values_valid = latched_any;
    for (int i = 0; i < OUT_REGS; i++) begin
      r.regs[i] = (i < REG_COUNT_DEF) ? latched[i] : 16'h0000;
    end
    return r;
  endfunction

  // Advance the mirror by one accepted word; hit says a reply is due.
  task automatic advance_model(input logic [1:0] op, input logic [7:0] b,
                               output bit hit, output mbrc_result_t r);
    int unsigned pos;
    int unsigned ri;
    logic [15:0] got;
    hit = 1'b0;
    r   = '0;
    if (op == OP_START) begin
      frame_on = 1'b1;
      nbytes   = 0;
      crc_acc  = CRC_INIT;
      hdr_good = 1'b1;
      quiet    = 16'h0000;
      crc_lo   = 8'h00;
    end else if (!frame_on || op == OP_RSVD) begin
      // drop: nothing to do outside a frame
    end else if (op == OP_TICK) begin
      if (quiet != 16'hFFFF) begin
        quiet = quiet + 16'd1;
      end
      if (quiet >= m_tmo) begin
        frame_on = 1'b0;
        hit      = 1'b1;
        r        = fill_reply((nbytes == 0) ? ST_TIMEOUT : ST_SHORT);
      end
    end else begin
      quiet  = 16'h0000;
      pos    = nbytes;
      nbytes = nbytes + 1;
      if (pos < CRC_SPAN) begin
        crc_acc = crc16_step(crc_acc, b);
        if (pos == 0 && b != m_addr) hdr_good = 1'b0;
        if (pos == 1 && b != m_func) hdr_good = 1'b0;
        if (pos == 2 && b != 8'(2 * REG_COUNT_DEF)) hdr_good = 1'b0;
        if (pos >= 3) begin
          ri = (pos - 3) >> 1;
          if (ri < REG_COUNT_DEF) begin
            if (((pos - 3) & 1) == 0) begin
              staged[ri][15:8] = b;
            end else begin
              staged[ri][7:0] = b;
            end
          end
        end
      end else if (pos == CRC_SPAN) begin
        crc_lo = b;
      end else begin
        // last byte: header first, then CRC, else latch the registers
        frame_on = 1'b0;
        got      = {b, crc_lo};
        hit      = 1'b1;
        if (!hdr_good) begin
          r = fill_reply(ST_HEADER);
        end else if (got != crc_acc) begin
          r = fill_reply(ST_CRC);
        end else begin
          for (int i = 0; i < REG_COUNT_DEF; i++) begin
            latched[i] = staged[i];
          end
          latched_any = 1'b1;
          r = fill_reply(ST_OK);
        end
      end
    end
  endtask

  task automatic check_field(string nm, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, nm, e, a);
      errors++;
    end
  endtask

  // Monitor: predict on every accepted request word, check every accepted result word.
  always @(posedge clk_i) begin : mon
    bit           hit;
    mbrc_result_t r;
    mbrc_result_t e;
    logic [15:0]  act [OUT_REGS];
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        advance_model(req_if.operation, req_if.rx_byte, hit, r);
        if (pin_en) begin
          // typed-in status and count override the mirror's, values stay mirrored
          if (!hit) r = fill_reply(pin_st);
          r.status     = pin_st;
          r.byte_count = pin_cnt;
          hit          = 1'b1;
        end
        if (hit) reply_q.push_back(r);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          $display("%0t: result word with none expected, status %0d count %0d",
                   $time, rsp_if.status, rsp_if.byte_count);
          errors++;
        end else begin
          e      = reply_q.pop_front();
          act[0] = rsp_if.humidity_raw;
          act[1] = rsp_if.temperature_raw;
          act[2] = rsp_if.conductivity;
          act[3] = rsp_if.ph_raw;
          act[4] = rsp_if.nitrogen;
          act[5] = rsp_if.phosphorus;
          act[6] = rsp_if.potassium;
          check_field("status", 16'(e.status), 16'(rsp_if.status));
          check_field("byte_count", 16'(e.byte_count), 16'(rsp_if.byte_count));
          check_field("values_valid", 16'(e.values_valid), 16'(rsp_if.values_valid));
          for (int i = 0; i < OUT_REGS; i++) begin
            check_field(reg_name[i], e.regs[i], act[i]);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Present one word and hold it until accepted; idle gaps go in front of it.
  task automatic drive_word(input logic [1:0] op, input logic [7:0] b, input bit pin,
                            input status_e st, input logic [4:0] cnt);
    while ($urandom_range(99) < send_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.rx_byte   <= b;
    pin_en           <= pin;
    pin_st           <= st;
    pin_cnt          <= cnt;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] b);
    drive_word(op, b, 1'b0, ST_OK, 5'd0);
  endtask

  // Stop offering words, wait for every reply, then let in-flight words clear.
  // It waits on the clock first, so the monitor has logged the last accepted word.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // Write all three registers back to back, keeping the write enable high.
  task automatic load_regs(input logic [7:0] a, input logic [7:0] f, input logic [15:0] t);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SLAVE_ADDR;
    cfg_wdata <= {8'h00, a};
    @(posedge clk_i);
    m_addr    = a;
    cfg_idx   <= CFG_FUNC_CODE;
    cfg_wdata <= {8'h00, f};
    @(posedge clk_i);
    m_func    = f;
    cfg_idx   <= CFG_TIMEOUT;
    cfg_wdata <= t;
    @(posedge clk_i);
    m_tmo     = t;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sprinkle a few silent ticks between bytes, always short of the timeout.
  task automatic maybe_quiet();
    int unsigned most;
    most = (m_tmo > 16'd4) ? 3 : m_tmo - 1;
    if (most > 0 && $urandom_range(9) == 0) begin
      repeat ($urandom_range(1, most)) send(OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  // Build and send one random frame of the given kind.
  task automatic gen_frame(input frame_kind_e kind);
    logic [7:0]  body [FRAME_BYTES];
    logic [15:0] c;
    int unsigned n;
    if (kind == K_NOISE) begin
      // raw words of any operation, including starts that drop a frame
      repeat ($urandom_range(1, 6)) send(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    body[0] = m_addr;
    body[1] = m_func;
    body[2] = 8'(2 * REG_COUNT_DEF);
    for (int i = 3; i < CRC_SPAN; i++) body[i] = rand_byte();
    if (kind == K_BAD_HDR) body[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
    c = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) c = crc16_step(c, body[i]);
    body[CRC_SPAN]     = c[7:0];
    body[CRC_SPAN + 1] = c[15:8];
    // a bad header may also carry a bad CRC, to show which one wins
    if (kind == K_BAD_CRC || (kind == K_BAD_HDR && $urandom_range(1) == 1)) begin
      body[CRC_SPAN + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
    end
    n = (kind == K_SHORT) ? $urandom_range(0, FRAME_BYTES - 1) : FRAME_BYTES;
    if (kind == K_SHORT && $urandom_range(1) == 1) begin
      for (int i = 0; i < FRAME_BYTES; i++) body[i] = 8'($urandom_range(255));
    end
    send(OP_START, rand_byte());
    for (int i = 0; i < n; i++) begin
      maybe_quiet();
      send(OP_BYTE, body[i]);
    end
    if (kind == K_SHORT) begin
      repeat (m_tmo) send(OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  initial begin : stim
    logic [15:0] walk_crc;
    int unsigned walk_n;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned base;
    frame_kind_e kind;

    // Drive every input to a known value from time zero.
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SLAVE_ADDR;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_START;
    req_if.rx_byte   = 8'h00;
    pin_en           = 1'b0;
    pin_st           = ST_OK;
    pin_cnt          = 5'd0;
    send_pct         = 0;
    stall_pct        = 0;
    hold_req         = 0;
    hold_left        = 0;

    // Mirror starts from the reset state.
    m_addr      = SLAVE_ADDR_RST;
    m_func      = FUNC_CODE_RST;
    m_tmo       = TIMEOUT_RST;
    frame_on    = 1'b0;
    nbytes      = 0;
    crc_acc     = CRC_INIT;
    hdr_good    = 1'b0;
    quiet       = 16'h0000;
    crc_lo      = 8'h00;
    latched_any = 1'b0;
    for (int i = 0; i < REG_COUNT_DEF; i++) begin
      staged[i]  = 16'h0000;
      latched[i] = 16'h0000;
    end

    dir_tab = '{
      // outside any frame: a byte and the unused operation do nothing
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_RSVD,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      // start, then silence before any byte: timeout with no bytes
      '{OP_START, 8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_TICK,  8'h00, CS_LIT, 1'b1, ST_TIMEOUT, 5'd0},
      // one byte, then silence: short frame
      '{OP_START, 8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h02, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_TICK,  8'h00, CS_LIT, 1'b1, ST_SHORT,   5'd1},
      // a frame dropped silently by the next start
      '{OP_START, 8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h55, CS_LIT, 1'b0, ST_OK,      5'd0},
      // full good frame with extreme register values
      '{OP_START, 8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h02, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h03, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h0E, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h80, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h7F, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hFF, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h5A, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'hA5, CS_LIT, 1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_LO,  1'b0, ST_OK,      5'd0},
      '{OP_BYTE,  8'h00, CS_HI,  1'b1, ST_OK,      5'd19},
      // tick after the frame closed: ignored
      '{OP_TICK,  8'h00, CS_LIT, 1'b0, ST_OK,      5'd0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: keep header defaults, make a single tick end a frame.
    load_regs(SLAVE_ADDR_RST, FUNC_CODE_RST, 16'd1);
    walk_crc = CRC_INIT;
    walk_n   = 0;
    foreach (dir_tab[i]) begin
      b = dir_tab[i].data;
      if (dir_tab[i].op == OP_START) begin
        walk_crc = CRC_INIT;
        walk_n   = 0;
      end else if (dir_tab[i].op == OP_BYTE) begin
        // fill the CRC rows from the bytes walked so far
        if (dir_tab[i].sel == CS_LO) begin
          b = walk_crc[7:0];
        end else if (dir_tab[i].sel == CS_HI) begin
          b = walk_crc[15:8];
        end
        if (walk_n < CRC_SPAN) walk_crc = crc16_step(walk_crc, b);
        walk_n++;
      end
      drive_word(dir_tab[i].op, b, dir_tab[i].pin, dir_tab[i].st, dir_tab[i].cnt);
    end
    settle();

    // Random phases, each with its own settings and idling pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          load_regs(8'h00, 8'h00, 16'd1);
          send_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          load_regs(8'hFF, 8'hFF, 16'd2);
          send_pct  = 46;
          stall_pct = 0;
        end
        2: begin
          load_regs(rand_byte(), rand_byte(), 16'($urandom_range(3, 12)));
          send_pct  = 0;
          stall_pct = 46;
          hold_req  = 1;   // long receiver hold-off while words keep coming
        end
        3: begin
          load_regs(SLAVE_ADDR_RST, FUNC_CODE_RST, 16'd24);
          send_pct  = 7;
          stall_pct = 7;
        end
        default: begin
          load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                    16'($urandom_range(1, 40)));
          send_pct  = 0;
          stall_pct = 0;
        end
      endcase
      sent = 0;
      base = replies_seen;
      while (sent < PHASE_WORDS || replies_seen - base < PHASE_REPLY) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          kind = K_GOOD;
        end else if (pick < 60) begin
          kind = K_BAD_CRC;
        end else if (pick < 72) begin
          kind = K_BAD_HDR;
        end else if (pick < 85) begin
          kind = K_SHORT;
        end else begin
          kind = K_NOISE;
        end
        gen_frame(kind);
      end
      settle();
    end

    // Zero timeout: the first tick of an active frame ends it.
    send_pct  = 0;
    stall_pct = 0;
    load_regs(rand_byte(), rand_byte(), 16'h0000);
    send(OP_START, rand_byte());
    send(OP_BYTE, rand_byte());
    drive_word(OP_TICK, 8'($urandom_range(255)), 1'b1, ST_SHORT, 5'd1);
    settle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: end the run if it hangs.
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
